// ----- rtl/kct_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the keyed count table.
package kct_pkg;

    // Default geometry of the table.
    localparam int SLOTS_DEF     = 32;
    localparam int KEY_WIDTH_DEF = 16;

    // Fixed field widths of the item and result ports.
    localparam int ITEM_KEY_W    = 16;
    localparam int MAX_KEY_WIDTH = 32;
    localparam int AMOUNT_W      = 8;

    // Depth of the queues on either side of the table engine.
    localparam int QUEUE_DEPTH   = 2;

    // Operation codes carried by the cmd field.
    typedef enum logic
    {
        OP_ADD = 1'b0,
        OP_SUB = 1'b1
    } op_t;

    // Result status codes.
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

endpackage

// ----- rtl/kct_fifo.sv -----
`timescale 1ns / 1ps
// Small register queue with push/full and pop/empty handshakes.
module kct_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = kct_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] dout
);
    import kct_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    // Handshake status follows the fill count.
    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // Pointer and count updates, wrapping at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- rtl/kct_back.sv -----
`timescale 1ns / 1ps
// Table engine: slot registers, parallel key compare and the slot update.
module kct_back #(
    parameter int SLOTS     = kct_pkg::SLOTS_DEF,
    parameter int KEY_WIDTH = kct_pkg::KEY_WIDTH_DEF,
    parameter int CMD_W     = 1 + kct_pkg::KEY_WIDTH_DEF + kct_pkg::AMOUNT_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_empty,
    input  logic [CMD_W-1:0] cmd_data,
    output logic             cmd_pop,
    input  logic             res_full,
    output logic             res_push,
    output logic             res_status
);
    import kct_pkg::*;

    typedef enum logic [1:0]
    {
        S_LOOK  = 2'b01,
        S_APPLY = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Slot storage.
    logic [KEY_WIDTH-1:0] key_reg [SLOTS];
    logic [AMOUNT_W-1:0]  cnt_reg [SLOTS];

    // Command held for the update cycle and the compare results.
    op_t                  op_reg;
    logic [KEY_WIDTH-1:0] ckey_reg;
    logic [AMOUNT_W-1:0]  amt_reg;
    logic [SLOTS-1:0]     match_reg;
    logic [SLOTS-1:0]     free_reg;

    // Fields of the item at the head of the command queue.
    op_t                  head_op;
    logic [KEY_WIDTH-1:0] head_key;
    logic [AMOUNT_W-1:0]  head_amt;
    logic [SLOTS-1:0]     match_next;
    logic [SLOTS-1:0]     free_next;

    // Update cycle signals.
    logic [SLOTS-1:0]     match_oh;
    logic [SLOTS-1:0]     free_oh;
    logic [SLOTS-1:0]     sel_oh;
    logic                 hit;
    logic                 free_avail;
    logic [AMOUNT_W-1:0]  match_cnt;
    logic                 fail;
    logic [KEY_WIDTH-1:0] new_key;
    logic [AMOUNT_W-1:0]  new_cnt;
    logic                 wr_en;

    assign head_op  = op_t'(cmd_data[CMD_W-1]);
    assign head_key = cmd_data[AMOUNT_W+KEY_WIDTH-1:AMOUNT_W];
    assign head_amt = cmd_data[AMOUNT_W-1:0];

    // Sequencer: compare the head item, then apply it once a result slot is free.
    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;
        case (state_reg)
            S_LOOK:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_LOOK;
                end
            end
            default:
            begin
                state_next = S_LOOK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOOK;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Every slot compares its key with the head item in parallel.
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            match_next[i] = (key_reg[i] == head_key);
            free_next[i]  = (key_reg[i] == '0) && (cnt_reg[i] == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            op_reg    <= head_op;
            ckey_reg  <= head_key;
            amt_reg   <= head_amt;
            match_reg <= match_next;
            free_reg  <= free_next;
        end
    end

    // Lowest matching slot and lowest empty slot, as one-hot vectors.
    assign match_oh   = match_reg & (~match_reg + 1'b1);
    assign free_oh    = free_reg & (~free_reg + 1'b1);
    assign hit        = |match_reg;
    assign free_avail = |free_reg;
    assign sel_oh     = hit ? match_oh : free_oh;

    // Count of the matching slot through a one-hot select.
    always_comb
    begin
        match_cnt = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            match_cnt = match_cnt | (cnt_reg[i] & {AMOUNT_W{match_oh[i]}});
        end
    end

    // Outcome of the operation and the value written to the chosen slot.
    always_comb
    begin
        fail    = 1'b0;
        new_key = ckey_reg;
        new_cnt = amt_reg;
        if (op_reg == OP_ADD)
        begin
            if (hit)
            begin
                new_cnt = match_cnt + amt_reg;
            end
            else if (!free_avail)
            begin
                fail = 1'b1;
            end
        end
        else
        begin
            if (!hit || (match_cnt < amt_reg))
            begin
                fail = 1'b1;
            end
            else if (match_cnt == amt_reg)
            begin
                // Count reaches zero, so the slot becomes empty.
                new_key = '0;
                new_cnt = '0;
            end
            else
            begin
                new_cnt = match_cnt - amt_reg;
            end
        end
    end

    assign wr_en      = res_push && !fail;
    assign res_status = fail ? ST_FAIL : ST_OK;

    // Slot registers clear at reset and take the update of the selected slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                key_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (sel_oh[i])
                begin
                    key_reg[i] <= new_key;
                    cnt_reg[i] <= new_cnt;
                end
            end
        end
    end

endmodule

// ----- rtl/keyed_count_table.sv -----
`timescale 1ns / 1ps
// Top level of the keyed count table: command queue, table engine and result queue.
//
//   Channel   Handshake          Fields
//   -------   ----------------   ---------------------------
//   item      push / full        cmd, item_key, amount
//   result    pop / empty        status
//
// In the table engine an item first gets the parallel key compare over all
// slots, then the lowest-slot pick and the count update. Items enter a
// two-entry command queue, then the engine's compare registers; results
// leave through a two-entry result queue.
// Reset clears every slot at once; the block takes items right after reset.
// A full result queue holds the engine in its update cycle; the command queue
// keeps taking items until it is full.
module keyed_count_table #(
    parameter int SLOTS     = kct_pkg::SLOTS_DEF,
    parameter int KEY_WIDTH = kct_pkg::KEY_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          cmd,
    input  logic [kct_pkg::ITEM_KEY_W-1:0] item_key,
    input  logic [kct_pkg::AMOUNT_W-1:0]   amount,
    output logic                          empty,
    input  logic                          pop,
    output logic                          status
);
    import kct_pkg::*;

    localparam int CMD_W = 1 + KEY_WIDTH + AMOUNT_W;

    logic [MAX_KEY_WIDTH-1:0] key_ext;
    logic [KEY_WIDTH-1:0]     key_in;
    logic [CMD_W-1:0]         cmd_in;
    logic [CMD_W-1:0]         cmd_head;
    logic                     cmd_empty;
    logic                     cmd_pop;
    logic                     res_full;
    logic                     res_push;
    logic                     res_status;

    // The key is taken to the table width before it is queued.
    assign key_ext = {{(MAX_KEY_WIDTH - ITEM_KEY_W){1'b0}}, item_key};
    assign key_in  = key_ext[KEY_WIDTH-1:0];
    assign cmd_in  = {cmd, key_in, amount};

    // Command queue between the item port and the engine.
    kct_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .din   (cmd_in),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .dout  (cmd_head)
    );

    // Table engine.
    kct_back #(
        .SLOTS     (SLOTS),
        .KEY_WIDTH (KEY_WIDTH),
        .CMD_W     (CMD_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_empty  (cmd_empty),
        .cmd_data   (cmd_head),
        .cmd_pop    (cmd_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_status (res_status)
    );

    // Result queue toward the result port.
    kct_fifo #(
        .WIDTH (1),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .din   (res_status),
        .pop   (pop),
        .empty (empty),
        .dout  (status)
    );

`ifndef ASSERT_OFF
    // The engine never writes a result into a full result queue.
    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result written while result queue full");

    // The engine only takes an item when the command queue holds one.
    a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command taken from empty queue");

    // An item taken from the queue is applied before the next one is taken.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> !cmd_pop)
        else $error("two items taken in consecutive cycles");

    // A result is written only in the cycle after a take or while one is pending.
    a_push_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !cmd_pop)
        else $error("result written in the same cycle as a new take");
`endif

endmodule

// ----- dv/kct_checker.sv -----
`timescale 1ns / 1ps
// Checker for the keyed count table: tracks the slot table and compares each status.
module kct_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic                           full,
    input  logic                           cmd,
    input  logic [kct_pkg::ITEM_KEY_W-1:0] item_key,
    input  logic [kct_pkg::AMOUNT_W-1:0]   amount,
    input  logic                           empty,
    input  logic                           pop,
    input  logic                           status,
    output int                             errors,
    output int                             pending
);
    import kct_pkg::*;

    localparam int NSLOT = SLOTS_DEF;
    localparam int KW    = KEY_WIDTH_DEF;

    // Shadow copy of the slot table.
    logic [KW-1:0]       tbl_key [NSLOT];
    logic [AMOUNT_W-1:0] tbl_cnt [NSLOT];

    // Statuses owed by the block, oldest first.
    logic status_due_q [$];
    logic want_status;

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    // Applies one add or subtract to the shadow table and returns its status.
    function automatic logic apply_stock_op(op_t op, logic [KW-1:0] key,
                                            logic [AMOUNT_W-1:0] amt);
        int hit;
        int free_slot;
        hit       = -1;
        free_slot = -1;
        // Scan downward so the lowest matching and lowest empty slots win.
        for (int i = NSLOT - 1; i >= 0; i--)
        begin
            if (tbl_key[i] == key)
                hit = i;
            if (tbl_key[i] == '0 && tbl_cnt[i] == '0)
                free_slot = i;
        end
        if (op == OP_ADD)
        begin
            if (hit >= 0)
            begin
                // The count wraps at eight bits.
                tbl_cnt[hit] = tbl_cnt[hit] + amt;
                return ST_OK;
            end
            if (free_slot < 0)
                return ST_FAIL;
            tbl_key[free_slot] = key;
            tbl_cnt[free_slot] = amt;
            return ST_OK;
        end
        if (hit < 0 || tbl_cnt[hit] < amt)
            return ST_FAIL;
        tbl_cnt[hit] = tbl_cnt[hit] - amt;
        // A count that lands on zero gives the slot back.
        if (tbl_cnt[hit] == '0)
            tbl_key[hit] = '0;
        return ST_OK;
    endfunction

    task automatic flag(string what, logic exp_v, logic act_v);
        if (errors < 10)
            $display("ERROR at %0t: %s: expected status %b, got %b", $realtime, what,
                     exp_v, act_v);
        errors++;
    endtask

    // Results are checked before the item of the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                tbl_key[i] = '0;
                tbl_cnt[i] = '0;
            end
            status_due_q.delete();
            pending = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (status_due_q.size() == 0)
                    flag("result with no item waiting", 1'bx, status);
                else
                begin
                    want_status = status_due_q.pop_front();
                    if (status !== want_status)
                        flag("status mismatch", want_status, status);
                end
            end
            if (push && !full)
                status_due_q.push_back(apply_stock_op(op_t'(cmd), item_key[KW-1:0], amount));
            pending = status_due_q.size();
        end
    end

endmodule

// ----- dv/tb_keyed_count_table.sv -----
`timescale 1ns / 1ps
// Testbench top for the keyed count table: clock, reset, stimulus and verdict.
module tb_keyed_count_table;
    import kct_pkg::*;

    localparam int POOL        = 40;
    localparam int HOLD_CYCLES = 64;
    localparam int IDLE_LIMIT  = 1000;
    localparam int PHASE_ITEMS = 85;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic                  cmd;
    logic [ITEM_KEY_W-1:0] item_key;
    logic [AMOUNT_W-1:0]   amount;
    logic                  empty;
    logic                  pop;
    logic                  status;

    int errors;
    int pending;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int idle_cycles  = 0;
    logic hold_req   = 1'b0;

    // Key pool larger than the table, so adds of new keys can find it full.
    logic [ITEM_KEY_W-1:0] key_pool [POOL];

    keyed_count_table i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .cmd      (cmd),
        .item_key (item_key),
        .amount   (amount),
        .empty    (empty),
        .pop      (pop),
        .status   (status)
    );

    kct_checker i_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .cmd      (cmd),
        .item_key (item_key),
        .amount   (amount),
        .empty    (empty),
        .pop      (pop),
        .status   (status),
        .errors   (errors),
        .pending  (pending)
    );

    always #5 clk = ~clk;

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            pop <= rst_n && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: too long without any item or result moving ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one item after an optional gap and returns once it is taken.
    task automatic send_item(op_t op, logic [ITEM_KEY_W-1:0] key, logic [AMOUNT_W-1:0] amt);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push     <= 1'b1;
        cmd      <= op;
        item_key <= key;
        amount   <= amt;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
    endtask

    // Mostly pooled keys with small amounts so counts return to zero; some noise.
    task automatic send_random_item();
        int                    r;
        int                    a;
        logic [ITEM_KEY_W-1:0] key;
        logic [AMOUNT_W-1:0]   amt;
        r = $urandom_range(99);
        if (r < 10)
            send_item(op_t'($urandom_range(1)), ITEM_KEY_W'($urandom), AMOUNT_W'($urandom));
        else
        begin
            key = key_pool[$urandom_range(POOL - 1)];
            a   = $urandom_range(99);
            amt = (a < 5) ? '0 : (a < 9) ? '1 : AMOUNT_W'($urandom_range(6, 1));
            if (r < 30)
            begin
                // Add followed by a subtract of the same amount.
                send_item(OP_ADD, key, amt);
                send_item(OP_SUB, key, amt);
            end
            else
                send_item(op_t'($urandom_range(1)), key, amt);
        end
    endtask

    // Stops offering items until every outstanding status has come back.
    task automatic drain();
        push <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        push     = 1'b0;
        cmd      = OP_ADD;
        item_key = '0;
        amount   = '0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL; i++)
            key_pool[i] = ITEM_KEY_W'($urandom_range(16'hFFFF, 1));
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed corner cases on a freshly cleared table.
        send_item(OP_SUB, 16'h0005, 8'd1);     // absent key
        send_item(OP_SUB, 16'h0000, 8'd0);     // key zero matches an empty slot
        send_item(OP_SUB, 16'h0000, 8'd1);     // count too small
        send_item(OP_ADD, 16'h0000, 8'd3);     // key zero adds to slot zero
        send_item(OP_ADD, 16'hFFFF, 8'd255);
        send_item(OP_ADD, 16'hFFFF, 8'd2);     // count wraps to one
        send_item(OP_SUB, 16'hFFFF, 8'd2);     // too small after the wrap
        send_item(OP_SUB, 16'hFFFF, 8'd1);     // frees the slot
        send_item(OP_ADD, 16'h1234, 8'd0);     // new key with a zero count
        send_item(OP_SUB, 16'h1234, 8'd0);     // subtract of zero frees it
        send_item(OP_ADD, 16'hAAAA, 8'd10);
        send_item(OP_ADD, 16'h5555, 8'd10);
        send_item(OP_SUB, 16'hAAAA, 8'd10);    // opens a hole below 16'h5555
        send_item(OP_ADD, 16'h5555, 8'd5);     // the match wins over the lower hole
        send_item(OP_SUB, 16'h5555, 8'd16);
        send_item(OP_SUB, 16'h5555, 8'd15);
        send_item(OP_SUB, 16'h0000, 8'd3);
        send_item(OP_ADD, 16'h8001, 8'd255);
        send_item(OP_SUB, 16'h8001, 8'd255);
        drain();

        // Random phases with different idling on either side.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 59; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 59; end
                default: begin tx_idle_pct = 18; rx_stall_pct = 18; end
            endcase
            if (ph == 0)
            begin
                // Hold the result side off while items keep coming.
                hold_req = 1'b1;
                repeat (20) send_random_item();
            end
            repeat (PHASE_ITEMS) send_random_item();
            drain();
        end

        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
